// ===== design/plt_pkg.sv =====
package plt_pkg;

  localparam int OutW = 48;
  localparam int DotW = 51;
  localparam int LenW = 66;
  localparam int NumW = 58;
  localparam int DenW = 64;
  localparam int PointW = 32;
  localparam int TW = 33;
  localparam int CfgW = 18;
  localparam int IdxW = 3;

  localparam logic signed [65:0] SatMax = 66'sh7FFF_FFFF_FFFF;
  localparam logic signed [65:0] SatMin = -66'sh8000_0000_0000;
  localparam logic [63:0] Clamp62 = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_LCHK, S_DIV, S_DOT, S_Q, S_PULL, S_NN, S_CP, S_CN, S_EMIT
  } state_e;

  typedef enum logic [1:0] {SH_NONE, SH_15, SH_30, SH_31} shift_e;

  typedef enum logic [2:0] {
    REG_NX, REG_NY, REG_NZ, REG_SCALE, REG_LIMIT
  } reg_e;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    shift_e            sh;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [127:0]      prod;
    logic signed [63:0] res;
  } mul_rsp_t;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [65:0] sx48(logic signed [47:0] v);
    return {{18{v[47]}}, v};
  endfunction

  function automatic logic signed [65:0] sx64(logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > SatMax) r = SatMax[47:0];
    else if (v < SatMin) r = SatMin[47:0];
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ===== design/plt_mul.sv =====
module plt_mul import plt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  shift_e       sh_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;

  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh, shifted;
  logic [63:0]  mag;

  assign opa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign opb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp  = 64'(opa) * 64'(opb);

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= mag64(req_i.a);
      ub_q  <= mag64(req_i.b);
      neg_q <= req_i.a[63] ^ req_i.b[63];
      sh_q  <= req_i.sh;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  always_comb begin
    case (sh_q)
      SH_15:   shifted = acc_q >> 15;
      SH_30:   shifted = acc_q >> 30;
      SH_31:   shifted = acc_q >> 31;
      default: shifted = acc_q;
    endcase
    if (shifted > {64'd0, Clamp62}) mag = Clamp62;
    else mag = shifted[63:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.neg  = neg_q;
  assign rsp_o.prod = acc_q;
  assign rsp_o.res  = neg_q ? -$signed(mag) : $signed(mag);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without work");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 2'd3 |=> busy_q || done_q) else $error("lost product");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");

endmodule

// ===== design/plt_div.sv =====
module plt_div import plt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0] num_q, quo_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;
  logic            fits;

  assign trial = {rem_q, num_q[NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/planarity_block_assembler.sv =====
// Planarity block assembler.
// Input channel (in_valid_i / in_stall_o) takes one control point per transfer;
// final_point_i marks the last point of a curve. Output channel (out_valid_o /
// out_stall_i) gives one row per transfer: prev, self and next block entries,
// the right-hand entry and final_row_o on the last row for that point.
// The first point of a curve is only stored and gives no rows. Each later
// point gives three rows (six for the final point). Every product runs on one
// shared 32x32 partial-product multiplier, and the weight on a one-bit-a-cycle
// divider of 58 steps.
// in_stall_o is high from a point's transfer until its last row is loaded into
// the output register. A stalled receiver holds the sequencer at the row load;
// the last row may wait in the output register while the next point transfers.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and
// are expected only while the block is idle.
// Reset clears the curve state and the output valid flag and loads the register
// defaults: normal (0, 32767, 0), scale 131072, degenerate limit 43.
module planarity_block_assembler import plt_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PointW-1:0] point_x_i,
  input  logic signed [PointW-1:0] point_y_i,
  input  logic signed [PointW-1:0] point_z_i,
  input  logic                   final_point_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] prev_coef_0_o,
  output logic signed [OutW-1:0] prev_coef_1_o,
  output logic signed [OutW-1:0] prev_coef_2_o,
  output logic signed [OutW-1:0] self_coef_0_o,
  output logic signed [OutW-1:0] self_coef_1_o,
  output logic signed [OutW-1:0] self_coef_2_o,
  output logic signed [OutW-1:0] next_coef_0_o,
  output logic signed [OutW-1:0] next_coef_1_o,
  output logic signed [OutW-1:0] next_coef_2_o,
  output logic signed [OutW-1:0] rhs_value_o,
  output logic                   final_row_o
);

  localparam logic [NumW-1:0] WMax = NumW'(SatMax);

  // configuration
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [17:0]        scale_q;
  logic [15:0]        limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q    <= 16'sd0;
      ny_q    <= 16'sd32767;
      nz_q    <= 16'sd0;
      scale_q <= 18'd131072;
      limit_q <= 16'd43;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NX:    nx_q    <= cfg_data_i[15:0];
        REG_NY:    ny_q    <= cfg_data_i[15:0];
        REG_NZ:    nz_q    <= cfg_data_i[15:0];
        REG_SCALE: scale_q <= cfg_data_i;
        REG_LIMIT: limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] nvec [3];
  assign nvec[0] = nx_q;
  assign nvec[1] = ny_q;
  assign nvec[2] = nz_q;

  // state
  state_e state_q, state_d;
  logic signed [COORD_WIDTH-1:0] held_q [3], held_d [3];
  logic signed [COORD_WIDTH-1:0] p_q [3], p_d [3];
  logic signed [TW-1:0]          t_q [3], t_d [3];
  logic signed [OutW-1:0]        ep_q [3], ep_d [3];
  logic signed [OutW-1:0]        pull_q [3], pull_d [3];
  logic signed [OutW-1:0]        cp_q [3], cp_d [3];
  logic signed [OutW-1:0]        cn_q [3], cn_d [3];
  logic signed [OutW-1:0]        ew_q, ew_d, w_q, w_d;
  logic                          seen_q, seen_d, fin_q, fin_d;
  logic                          pend_q, pend_d, pass_q, pass_d;
  logic [1:0]                    idx_q, idx_d, row_q, row_d, col_q, col_d;
  logic [LenW-1:0]               len_q, len_d;
  logic signed [DotW-1:0]        dot_q, dot_d;
  logic signed [63:0]            qv_q, qv_d, nn_q, nn_d;

  // output register
  logic                   ov_q, ov_d;
  logic signed [OutW-1:0] prv_q [3], prv_d [3];
  logic signed [OutW-1:0] slf_q [3], slf_d [3];
  logic signed [OutW-1:0] nxt_q [3], nxt_d [3];
  logic signed [OutW-1:0] rhs_q, rhs_d;
  logic                   frow_q, frow_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     mul_st, div_start, div_done;
  logic [NumW-1:0] quo;

  logic signed [COORD_WIDTH-1:0] pin [3];
  assign pin[0] = point_x_i[COORD_WIDTH-1:0];
  assign pin[1] = point_y_i[COORD_WIDTH-1:0];
  assign pin[2] = point_z_i[COORD_WIDTH-1:0];

  logic signed [OutW-1:0] wp, wn, pp, pn;
  logic signed [63:0]     prod_s;

  assign wp = pass_q ? w_q : ew_q;
  assign wn = pass_q ? '0 : w_q;
  assign pp = pass_q ? pull_q[row_q] : ep_q[row_q];
  assign pn = pass_q ? '0 : pull_q[row_q];
  assign prod_s = mrsp.neg ? -$signed(mrsp.prod[63:0]) : $signed(mrsp.prod[63:0]);

  assign mul_st = state_q inside {S_SQ, S_DOT, S_Q, S_PULL, S_NN, S_CP, S_CN};
  assign in_stall_o = (state_q != S_IDLE);

  plt_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  plt_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i({scale_q, 40'd0}),
    .den_i(len_q[DenW-1:0]),
    .done_o(div_done),
    .quo_o(quo)
  );

  always_comb begin
    state_d = state_q;
    held_d = held_q; p_d = p_q; t_d = t_q; ep_d = ep_q; pull_d = pull_q;
    cp_d = cp_q; cn_d = cn_q; ew_d = ew_q; w_d = w_q;
    seen_d = seen_q; fin_d = fin_q; pend_d = pend_q; pass_d = pass_q;
    idx_d = idx_q; row_d = row_q; col_d = col_q;
    len_d = len_q; dot_d = dot_q; qv_d = qv_q; nn_d = nn_q;
    ov_d = ov_q && out_stall_i;
    prv_d = prv_q; slf_d = slf_q; nxt_d = nxt_q; rhs_d = rhs_q; frow_d = frow_q;
    div_start = 1'b0;

    mreq.start = mul_st && !pend_q;
    mreq.a     = '0;
    mreq.b     = '0;
    mreq.sh    = SH_NONE;
    if (mreq.start) pend_d = 1'b1;
    if (mrsp.done) pend_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!seen_q) begin
            ew_d = '0;
            for (int i = 0; i < 3; i++) begin
              ep_d[i]   = '0;
              held_d[i] = fin_q ? '0 : '0;
            end
            if (!final_point_i) begin
              held_d = pin;
              seen_d = 1'b1;
            end
          end else begin
            p_d = pin;
            for (int i = 0; i < 3; i++) t_d[i] = TW'(pin[i]) - TW'(held_q[i]);
            fin_d   = final_point_i;
            len_d   = '0;
            dot_d   = '0;
            idx_d   = 2'd0;
            state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        mreq.a = 64'(t_q[idx_q]);
        mreq.b = 64'(t_q[idx_q]);
        if (mrsp.done) begin
          len_d = len_q + mrsp.prod[LenW-1:0];
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd2) state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        idx_d = 2'd0;
        if (len_q[LenW-1:DenW] != '0 || len_q <= LenW'(limit_q)) begin
          w_d     = '0;
          state_d = S_DOT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          w_d     = (quo > WMax) ? SatMax[OutW-1:0] : quo[OutW-1:0];
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        mreq.a = 64'(nvec[idx_q]);
        mreq.b = 64'(t_q[idx_q]);
        if (mrsp.done) begin
          dot_d = dot_q + prod_s[DotW-1:0];
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            idx_d   = 2'd0;
            state_d = S_Q;
          end
        end
      end
      S_Q: begin
        mreq.a  = 64'(nvec[idx_q]);
        mreq.b  = 64'(dot_q);
        mreq.sh = SH_15;
        if (mrsp.done) begin
          qv_d    = mrsp.res;
          state_d = S_PULL;
        end
      end
      S_PULL: begin
        mreq.a  = 64'(w_q);
        mreq.b  = qv_q;
        mreq.sh = SH_31;
        if (mrsp.done) begin
          pull_d[idx_q] = sat48(sx64(mrsp.res));
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            pass_d  = 1'b0;
            row_d   = 2'd0;
            col_d   = 2'd0;
            state_d = S_NN;
          end else begin
            state_d = S_Q;
          end
        end
      end
      S_NN: begin
        mreq.a = 64'(nvec[row_q]);
        mreq.b = 64'(nvec[col_q]);
        if (mrsp.done) begin
          nn_d    = prod_s;
          state_d = S_CP;
        end
      end
      S_CP: begin
        mreq.a  = 64'(wp);
        mreq.b  = nn_q;
        mreq.sh = SH_30;
        if (mrsp.done) begin
          cp_d[col_q] = sat48(sx64(mrsp.res));
          state_d     = S_CN;
        end
      end
      S_CN: begin
        mreq.a  = 64'(wn);
        mreq.b  = nn_q;
        mreq.sh = SH_30;
        if (mrsp.done) begin
          cn_d[col_q] = sat48(sx64(mrsp.res));
          col_d = col_q + 2'd1;
          if (col_q == 2'd2) begin
            col_d   = 2'd0;
            state_d = S_EMIT;
          end else begin
            state_d = S_NN;
          end
        end
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          for (int j = 0; j < 3; j++) begin
            prv_d[j] = sat48(-sx48(cp_q[j]));
            slf_d[j] = sat48(sx48(cp_q[j]) + sx48(cn_q[j]));
            nxt_d[j] = sat48(-sx48(cn_q[j]));
          end
          rhs_d  = sat48(sx48(pn) - sx48(pp));
          frow_d = (row_q == 2'd2) && (pass_q || !fin_q);
          row_d  = row_q + 2'd1;
          state_d = S_NN;
          if (row_q == 2'd2) begin
            row_d = 2'd0;
            if (!pass_q && fin_q) begin
              pass_d = 1'b1;
            end else begin
              state_d = S_IDLE;
              if (fin_q) begin
                seen_d = 1'b0;
                ew_d   = '0;
                for (int i = 0; i < 3; i++) begin
                  held_d[i] = '0;
                  ep_d[i]   = '0;
                end
              end else begin
                held_d = p_q;
                ep_d   = pull_q;
                ew_d   = w_q;
              end
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seen_q  <= 1'b0;
      fin_q   <= 1'b0;
      pend_q  <= 1'b0;
      pass_q  <= 1'b0;
      idx_q   <= 2'd0;
      row_q   <= 2'd0;
      col_q   <= 2'd0;
      ov_q    <= 1'b0;
      ew_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        held_q[i] <= '0;
        ep_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      fin_q   <= fin_d;
      pend_q  <= pend_d;
      pass_q  <= pass_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      col_q   <= col_d;
      ov_q    <= ov_d;
      ew_q    <= ew_d;
      held_q  <= held_d;
      ep_q    <= ep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t_q    <= t_d;
    pull_q <= pull_d;
    cp_q   <= cp_d;
    cn_q   <= cn_d;
    w_q    <= w_d;
    len_q  <= len_d;
    dot_q  <= dot_d;
    qv_q   <= qv_d;
    nn_q   <= nn_d;
    prv_q  <= prv_d;
    slf_q  <= slf_d;
    nxt_q  <= nxt_d;
    rhs_q  <= rhs_d;
    frow_q <= frow_d;
  end

  assign out_valid_o   = ov_q;
  assign prev_coef_0_o = prv_q[0];
  assign prev_coef_1_o = prv_q[1];
  assign prev_coef_2_o = prv_q[2];
  assign self_coef_0_o = slf_q[0];
  assign self_coef_1_o = slf_q[1];
  assign self_coef_2_o = slf_q[2];
  assign next_coef_0_o = nxt_q[0];
  assign next_coef_1_o = nxt_q[1];
  assign next_coef_2_o = nxt_q[2];
  assign rhs_value_o   = rhs_q;
  assign final_row_o   = frow_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_q) else $error("product pending in idle");
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> pend_q && mul_st) else $error("stray product");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("stray quotient");
  a_clear_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> ew_q == '0) else $error("weight kept without a point");

endmodule
